// ===== src/ray_sphere_nearest_hit_core_macros.svh =====
// Assertion macros for the ray/sphere nearest-hit core.
// Each macro expects clk and arst_n in the scope that uses it.
`ifndef RAY_SPHERE_NEAREST_HIT_CORE_MACROS_SVH
`define RAY_SPHERE_NEAREST_HIT_CORE_MACROS_SVH

// property that holds at every clock edge outside reset
`define RSNH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define RSNH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rsnh_pkg.sv =====
// Shared types and constants for the ray/sphere nearest-hit core.
// No dependencies.
package rsnh_pkg;

	localparam int MAX_SPHERES = 16;
	localparam int IDX_W       = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
	localparam int CNT_W       = $clog2(MAX_SPHERES + 1);
	localparam int QUEUE_DEPTH = 2;

	localparam int MUL_W       = 144;
	localparam int OPD_W       = 72;
	localparam int SHORT_LEN   = 34;
	localparam int LONG_LEN    = 68;
	localparam int STEP_W      = 7;
	localparam int SQRT_STEPS  = 72;
	localparam int ROOT_W      = 72;
	localparam int SREM_W      = 76;
	localparam int NUM_W       = 88;
	localparam int A_W         = 64;
	localparam int HK_W        = 68;

	typedef enum logic [1:0] {
		CFG_ACTIVE = 2'd0,
		CFG_MIN    = 2'd1,
		CFG_MAX    = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_TRACE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		JOB_LOAD,
		JOB_TRACE,
		JOB_SKIP
	} job_op_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_ADIR,
		B_SPH,
		B_HDOT,
		B_KDOT,
		B_DISC,
		B_SQRT,
		B_ROOT1,
		B_ROOT2,
		B_DONE
	} back_state_t;

	typedef struct packed {
		kind_t              kind;
		logic [3:0]         slot;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic [30:0]        sphere_radius;
		logic [31:0]        sphere_brightness;
	} item_t;

	typedef struct packed {
		logic [31:0] brightness;
		logic        hit;
	} result_t;

	typedef struct packed {
		logic [4:0]         active;
		logic signed [31:0] min_dist;
		logic signed [31:0] max_dist;
	} cfg_t;

	typedef struct packed {
		job_op_t op;
		item_t   item;
	} job_t;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [30:0]        radius;
		logic [31:0]        bright;
	} sphere_t;

endpackage

// ===== src/rsnh_front.sv =====
// Front end: configuration registers, item acceptance and classification.
// Depends on rsnh_pkg.
module rsnh_front import rsnh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  item_t      item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t       cfg,
	output logic       push,
	output job_t       job,
	input  logic       full
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active   <= 5'd0;
			cfg_q.min_dist <= 32'sd65536;
			cfg_q.max_dist <= 32'sh7FFF_FFFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ACTIVE: cfg_q.active   <= cfg_data[4:0];
				CFG_MIN:    cfg_q.min_dist <= cfg_data;
				CFG_MAX:    cfg_q.max_dist <= cfg_data;
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;
	assign busy      = full;
	assign push      = start && !full;

	always_comb begin
		job.item = item;
		if (item.kind == KIND_TRACE)
			job.op = JOB_TRACE;
		else if (int'(item.slot) < MAX_SPHERES)
			job.op = JOB_LOAD;
		else
			job.op = JOB_SKIP;
	end

endmodule

// ===== src/rsnh_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on rsnh_pkg and the core assertion macros.
`include "ray_sphere_nearest_hit_core_macros.svh"
module rsnh_queue import rsnh_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t job_in,
	input  logic pop,
	output job_t job_out,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	job_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= job_in;
	end

	assign job_out = slots_q[rd_ptr_q];
	assign empty   = (count_q == '0);
	assign full    = (int'(count_q) == QUEUE_DEPTH);

	`RSNH_ASSERT(a_no_overflow, !(push && full), "push into full queue")
	`RSNH_ASSERT(a_no_underflow, !(pop && empty), "pop from empty queue")
	`RSNH_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "count lost")

endmodule

// ===== src/rsnh_back.sv =====
// Back end: sphere table, shared multiply-accumulate, square root and divider.
// Depends on rsnh_pkg and the core assertion macros.
`include "ray_sphere_nearest_hit_core_macros.svh"
module rsnh_back import rsnh_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  job_t    job,
	input  logic    empty,
	output logic    pop,
	output logic    done,
	output result_t result
);

	back_state_t state_q, state_d;

	sphere_t tbl_q [MAX_SPHERES];

	logic signed [31:0] org_x_q, org_y_q, org_z_q;
	logic signed [31:0] dir_x_q, dir_y_q, dir_z_q;
	logic signed [32:0] ox_q, oy_q, oz_q;
	logic [30:0]        rad_q;
	logic [31:0]        brt_q;
	logic [A_W-1:0]     a_q;
	logic signed [HK_W-1:0] h_q, k_q;

	logic signed [MUL_W-1:0] acc_q, ma_q, addend, acc_nx;
	logic [OPD_W-1:0]        mb_q, opb_mag;
	logic                    mneg_q, mld_q;
	logic [STEP_W-1:0]       mcnt_q;
	logic [1:0]              term_q;
	logic signed [OPD_W-1:0] opa, opb;
	logic                    osub, olast;
	logic [STEP_W-1:0]       olen;
	logic                    term_end, mac_fin;

	logic [MUL_W-1:0]  srad_q;
	logic [SREM_W-1:0] srem_q, strial, scand, srem_nx;
	logic [ROOT_W-1:0] sroot_q, sroot_nx;
	logic [STEP_W-1:0] scnt_q;
	logic              sok, sqrt_fin;

	logic [NUM_W-1:0]  dnum_q, dquo_q, dquo_nx;
	logic [A_W-1:0]    drem_q, drem_nx;
	logic [A_W:0]      dtrial;
	logic              dneg_q, dge, div_fin;
	logic [STEP_W-1:0] dcnt_q;
	logic [NUM_W:0]    qadj;
	logic signed [31:0] troot;
	logic              take;

	logic signed [73:0] n1, n2, n1_mag, n2_mag;
	logic [89:0]        n1_sh, n2_sh;

	logic [CNT_W-1:0]   kidx_q, nlim;
	logic               found_q;
	logic signed [31:0] best_q;
	logic [31:0]        bright_q;

	assign nlim = (int'(cfg.active) > MAX_SPHERES) ? CNT_W'(MAX_SPHERES) : CNT_W'(cfg.active);

	always_comb begin
		opa   = '0;
		opb   = '0;
		osub  = 1'b0;
		olast = 1'b0;
		olen  = STEP_W'(SHORT_LEN);
		unique case (state_q)
			B_ADIR: begin
				olast = (term_q == 2'd2);
				unique case (term_q)
					2'd0:    begin opa = OPD_W'(dir_x_q); opb = OPD_W'(dir_x_q); end
					2'd1:    begin opa = OPD_W'(dir_y_q); opb = OPD_W'(dir_y_q); end
					default: begin opa = OPD_W'(dir_z_q); opb = OPD_W'(dir_z_q); end
				endcase
			end
			B_HDOT: begin
				olast = (term_q == 2'd2);
				unique case (term_q)
					2'd0:    begin opa = OPD_W'(ox_q); opb = OPD_W'(dir_x_q); end
					2'd1:    begin opa = OPD_W'(oy_q); opb = OPD_W'(dir_y_q); end
					default: begin opa = OPD_W'(oz_q); opb = OPD_W'(dir_z_q); end
				endcase
			end
			B_KDOT: begin
				olast = (term_q == 2'd3);
				unique case (term_q)
					2'd0: begin opa = OPD_W'(ox_q); opb = OPD_W'(ox_q); end
					2'd1: begin opa = OPD_W'(oy_q); opb = OPD_W'(oy_q); end
					2'd2: begin opa = OPD_W'(oz_q); opb = OPD_W'(oz_q); end
					default: begin
						opa  = OPD_W'({1'b0, rad_q});
						opb  = OPD_W'({1'b0, rad_q});
						osub = 1'b1;
					end
				endcase
			end
			B_DISC: begin
				olen  = STEP_W'(LONG_LEN);
				olast = (term_q == 2'd1);
				if (term_q == 2'd0) begin
					opa = OPD_W'(h_q);
					opb = OPD_W'(h_q);
				end else begin
					opa  = OPD_W'({1'b0, a_q});
					opb  = OPD_W'(k_q);
					osub = 1'b1;
				end
			end
			default: begin
				opa = '0;
			end
		endcase
	end

	assign opb_mag  = opb[OPD_W-1] ? OPD_W'(-opb) : OPD_W'(opb);
	assign addend   = mb_q[0] ? ma_q : '0;
	assign acc_nx   = mneg_q ? acc_q - addend : acc_q + addend;
	assign term_end = !mld_q && (mcnt_q == olen - 1'b1);
	assign mac_fin  = term_end && olast;

	assign strial   = {srem_q[SREM_W-3:0], srad_q[MUL_W-1 -: 2]};
	assign scand    = SREM_W'({sroot_q, 2'b01});
	assign sok      = (strial >= scand);
	assign srem_nx  = sok ? strial - scand : strial;
	assign sroot_nx = {sroot_q[ROOT_W-2:0], sok};
	assign sqrt_fin = (int'(scnt_q) == SQRT_STEPS - 1);

	assign n1     = $signed({2'b00, sroot_nx}) - 74'(h_q);
	assign n1_mag = n1[73] ? -n1 : n1;
	assign n1_sh  = {n1_mag, 16'b0};
	assign n2     = -74'(h_q) - $signed({2'b00, sroot_q});
	assign n2_mag = n2[73] ? -n2 : n2;
	assign n2_sh  = {n2_mag, 16'b0};

	assign dtrial  = {drem_q, dnum_q[NUM_W-1]};
	assign dge     = (dtrial >= {1'b0, a_q});
	assign drem_nx = dge ? A_W'(dtrial - {1'b0, a_q}) : dtrial[A_W-1:0];
	assign dquo_nx = {dquo_q[NUM_W-2:0], dge};
	assign div_fin = (int'(dcnt_q) == NUM_W - 1);
	assign qadj    = {1'b0, dquo_nx} + (NUM_W + 1)'(drem_nx != '0);

	always_comb begin
		if (!dneg_q)
			troot = (dquo_nx > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
			                                          : $signed(dquo_nx[31:0]);
		else if (qadj > (NUM_W + 1)'(33'h1_0000_0000 >> 1))
			troot = 32'sh8000_0000;
		else
			troot = $signed(32'((NUM_W + 1)'(0) - qadj));
		take = (troot >= cfg.min_dist) && (troot <= cfg.max_dist)
		       && (!found_q || troot < best_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:  if (!empty && job.op == JOB_TRACE) state_d = B_ADIR;
			B_ADIR:  if (mac_fin) state_d = B_SPH;
			B_SPH:   state_d = (a_q == '0 || kidx_q >= nlim) ? B_DONE : B_HDOT;
			B_HDOT:  if (mac_fin) state_d = B_KDOT;
			B_KDOT:  if (mac_fin) state_d = B_DISC;
			B_DISC:  if (mac_fin) state_d = acc_nx[MUL_W-1] ? B_SPH : B_SQRT;
			B_SQRT:  if (sqrt_fin) state_d = B_ROOT1;
			B_ROOT1: if (div_fin) state_d = B_ROOT2;
			B_ROOT2: if (div_fin) state_d = B_SPH;
			B_DONE:  state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop               = (state_q == B_IDLE) && !empty;
		done              = (state_q == B_DONE);
		result.brightness = found_q ? bright_q : 32'd0;
		result.hit        = found_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			found_q <= 1'b0;
			mld_q   <= 1'b1;
			term_q  <= 2'd0;
			kidx_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				mld_q  <= 1'b1;
				term_q <= 2'd0;
			end else if (term_end) begin
				mld_q  <= 1'b1;
				term_q <= term_q + 1'b1;
			end else if (mld_q) begin
				mld_q <= 1'b0;
			end
			if (pop && job.op == JOB_TRACE) begin
				found_q <= 1'b0;
				kidx_q  <= '0;
			end
			if ((state_q == B_DISC && mac_fin && acc_nx[MUL_W-1])
			    || (state_q == B_ROOT2 && div_fin))
				kidx_q <= kidx_q + 1'b1;
			if ((state_q == B_ROOT1 || state_q == B_ROOT2) && div_fin && take)
				found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && job.op == JOB_LOAD) begin
			tbl_q[job.item.slot[IDX_W-1:0]].cx     <= job.item.point_x;
			tbl_q[job.item.slot[IDX_W-1:0]].cy     <= job.item.point_y;
			tbl_q[job.item.slot[IDX_W-1:0]].cz     <= job.item.point_z;
			tbl_q[job.item.slot[IDX_W-1:0]].radius <= job.item.sphere_radius;
			tbl_q[job.item.slot[IDX_W-1:0]].bright <= job.item.sphere_brightness;
		end
		if (pop && job.op == JOB_TRACE) begin
			org_x_q <= job.item.point_x;
			org_y_q <= job.item.point_y;
			org_z_q <= job.item.point_z;
			dir_x_q <= job.item.dir_x;
			dir_y_q <= job.item.dir_y;
			dir_z_q <= job.item.dir_z;
		end
		if (state_q == B_SPH) begin
			ox_q  <= 33'(org_x_q) - 33'(tbl_q[kidx_q[IDX_W-1:0]].cx);
			oy_q  <= 33'(org_y_q) - 33'(tbl_q[kidx_q[IDX_W-1:0]].cy);
			oz_q  <= 33'(org_z_q) - 33'(tbl_q[kidx_q[IDX_W-1:0]].cz);
			rad_q <= tbl_q[kidx_q[IDX_W-1:0]].radius;
			brt_q <= tbl_q[kidx_q[IDX_W-1:0]].bright;
		end

		if (state_d != state_q) begin
			acc_q <= '0;
		end else if (mld_q) begin
			ma_q   <= MUL_W'(opa);
			mb_q   <= opb_mag;
			mneg_q <= opb[OPD_W-1] ^ osub;
			mcnt_q <= '0;
		end else begin
			acc_q  <= acc_nx;
			ma_q   <= ma_q <<< 1;
			mb_q   <= mb_q >> 1;
			mcnt_q <= mcnt_q + 1'b1;
		end
		if (mac_fin) begin
			unique case (state_q)
				B_ADIR:  a_q <= acc_nx[A_W-1:0];
				B_HDOT:  h_q <= acc_nx[HK_W-1:0];
				B_KDOT:  k_q <= acc_nx[HK_W-1:0];
				default: begin
					srad_q  <= acc_nx;
					srem_q  <= '0;
					sroot_q <= '0;
					scnt_q  <= '0;
				end
			endcase
		end

		if (state_q == B_SQRT) begin
			srad_q  <= srad_q << 2;
			srem_q  <= srem_nx;
			sroot_q <= sroot_nx;
			scnt_q  <= scnt_q + 1'b1;
			if (sqrt_fin) begin
				dnum_q <= n1_sh[NUM_W-1:0];
				dneg_q <= n1[73];
				drem_q <= '0;
				dquo_q <= '0;
				dcnt_q <= '0;
			end
		end

		if (state_q == B_ROOT1 || state_q == B_ROOT2) begin
			if (div_fin && take) begin
				best_q   <= troot;
				bright_q <= brt_q;
			end
			if (state_q == B_ROOT1 && div_fin) begin
				dnum_q <= n2_sh[NUM_W-1:0];
				dneg_q <= n2[73];
				drem_q <= '0;
				dquo_q <= '0;
				dcnt_q <= '0;
			end else begin
				dnum_q <= dnum_q << 1;
				drem_q <= drem_nx;
				dquo_q <= dquo_nx;
				dcnt_q <= dcnt_q + 1'b1;
			end
		end
	end

	`RSNH_ASSERT_NEXT(a_done_strobe, done, !done, "done held longer than one cycle")
	`RSNH_ASSERT(a_pop_nonempty, !(pop && empty), "pop while queue empty")
	`RSNH_ASSERT_NEXT(a_trace_clears, pop && job.op == JOB_TRACE, !result.hit, "hit not cleared")

endmodule

// ===== src/ray_sphere_nearest_hit_core.sv =====
// Top level of the ray/sphere nearest-hit core.
// Depends on rsnh_pkg, rsnh_front, rsnh_queue and rsnh_back.
//
// Usage:
//   Items enter on start/item and are taken at an edge where start is high and
//   busy is low. A load item (kind 0) writes one sphere slot and returns nothing.
//   A trace item (kind 1) returns one transaction on result, marked by a one-cycle
//   done strobe; the receiver cannot stall and must take it in that cycle.
//   Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Write them only while the core is idle.
//   Items pass a two-entry queue, so busy rises only when two items wait.
//   A load writes its sphere slot as the back end pops it. A trace visits each
//   active sphere in turn through the bit-serial multiply-accumulate (one bit a
//   cycle), the 72-step square root and two 88-step restoring divisions, all shared;
//   a sphere whose discriminant is negative skips the square root and divisions.
//   Reset clears the queue, control and registers to their defaults (active 0,
//   min 1.0, max full scale); the sphere table is undefined until loaded.
module ray_sphere_nearest_hit_core import rsnh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t cfg;
	logic push, pop, empty, full;
	job_t job_in, job_out;

	rsnh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.push      (push),
		.job       (job_in),
		.full      (full)
	);

	rsnh_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_in),
		.pop     (pop),
		.job_out (job_out),
		.empty   (empty),
		.full    (full)
	);

	rsnh_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.job    (job_out),
		.empty  (empty),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule
